// ===== rtl/cuckoo_filter_engine_assert.svh =====
// Assertion macros for the cuckoo filter engine checker
`ifndef CUCKOO_FILTER_ENGINE_ASSERT_SVH
`define CUCKOO_FILTER_ENGINE_ASSERT_SVH

// Checked only while out of reset
`define CFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define CFE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/cfe_pkg.sv =====
// Shared types, constants and the djb2 hash for the cuckoo filter engine
package cfe_pkg;

    localparam int unsigned BUCKET_COUNT_DEF = 128;
    localparam int unsigned FP_W             = 16;
    localparam int unsigned LIMIT_W          = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd8;
    localparam logic [FP_W-1:0]    DJB2_SEED   = 16'd5381;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // One queued request
    typedef struct packed {
        logic            op;
        logic            pick;
        logic [FP_W-1:0] fp;
    } t_item;

    // 16-bit djb2 over two bytes, low byte first
    function automatic logic [FP_W-1:0] djb2_word(input logic [FP_W-1:0] w);
        logic [FP_W-1:0] h;
        h = DJB2_SEED;
        h = (h << 5) + h + {8'd0, w[7:0]};
        h = (h << 5) + h + {8'd0, w[15:8]};
        return h;
    endfunction

endpackage

// ===== rtl/cuckoo_filter_engine.sv =====
// Cuckoo filter engine top level: config register, front end and back end
//
// Usage:
//  - Request channel (i_valid/o_ready): i_op (0 insert, 1 lookup), i_key,
//    i_victim_pick. Result channel (o_valid/i_ready): o_ok,
//    o_relocations_used, o_fingerprint_out, one result beat per request.
//  - Config channel (i_cfg_valid/o_cfg_ready) writes relocation_limit;
//    write it only while the engine is idle. Reset value is 8.
//  - The front end hashes the key and holds up to two requests; the back
//    end works on one request at a time on a one-read, one-write table.
//  - A request waits in the queue; the back end then reads both candidate
//    buckets and loads the result register. An insert that evicts also
//    reads and checks alternate buckets, one table read and one table
//    write per relocation. The back end takes no new request until it
//    has loaded the result register for the last one.
//  - After reset the table is cleared, one bucket per cycle, over all
//    BUCKET_COUNT buckets; o_ready stays low during that sweep.
//  - When the receiver stalls, the result register holds, the back end
//    parks its next result, and the queue keeps taking beats until full.
module cuckoo_filter_engine #(
    parameter int unsigned BUCKET_COUNT = cfe_pkg::BUCKET_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_key,
    input  logic        i_victim_pick,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [7:0]  o_relocations_used,
    output logic [15:0] o_fingerprint_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import cfe_pkg::*;

    localparam int unsigned IW = $clog2(BUCKET_COUNT);

    logic [LIMIT_W-1:0] r_limit;
    logic               clearing, head_valid, pop;
    t_item              head;
    logic [IW-1:0]      head_i1, head_i2;

    assign o_cfg_ready = 1'b1;

    // Relocation limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    cfe_front #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .IW           (IW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_victim_pick (i_victim_pick),
        .i_clearing    (clearing),
        .o_head_valid  (head_valid),
        .o_head        (head),
        .o_head_i1     (head_i1),
        .o_head_i2     (head_i2),
        .i_pop         (pop)
    );

    cfe_back #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .IW           (IW)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_limit            (r_limit),
        .o_clearing         (clearing),
        .i_head_valid       (head_valid),
        .i_head             (head),
        .i_head_i1          (head_i1),
        .i_head_i2          (head_i2),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_ok               (o_ok),
        .o_relocations_used (o_relocations_used),
        .o_fingerprint_out  (o_fingerprint_out)
    );

endmodule

// ===== rtl/cfe_front.sv =====
// Front end: hashes keys into fingerprints and queues requests
module cfe_front #(
    parameter int unsigned BUCKET_COUNT = 128,
    parameter int unsigned IW           = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [15:0]           i_key,
    input  logic                  i_victim_pick,
    input  logic                  i_clearing,
    output logic                  o_head_valid,
    output cfe_pkg::t_item        o_head,
    output logic [IW-1:0]         o_head_i1,
    output logic [IW-1:0]         o_head_i2,
    input  logic                  i_pop
);
    import cfe_pkg::*;

    localparam logic [IW-1:0] MASK = IW'(BUCKET_COUNT - 1);
    localparam int unsigned   CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned   PW   = $clog2(QUEUE_DEPTH);

    t_item          r_q [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic [FP_W-1:0] head_hash;

    assign o_ready      = !i_clearing && (r_cnt != CW'(QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rd_ptr];

    // Both candidate buckets from the fingerprint at the head
    assign head_hash = djb2_word(o_head.fp);
    assign o_head_i1 = o_head.fp[IW-1:0] & MASK;
    assign o_head_i2 = o_head_i1 ^ (head_hash[IW-1:0] & MASK);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{op: i_op, pick: i_victim_pick, fp: djb2_word(i_key)};
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/cfe_back.sv =====
// Back end: bucket table, insert/relocate/lookup sequencer, result register
module cfe_back #(
    parameter int unsigned BUCKET_COUNT = 128,
    parameter int unsigned IW           = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cfe_pkg::LIMIT_W-1:0] i_limit,
    output logic                       o_clearing,
    input  logic                       i_head_valid,
    input  cfe_pkg::t_item             i_head,
    input  logic [IW-1:0]              i_head_i1,
    input  logic [IW-1:0]              i_head_i2,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_ok,
    output logic [7:0]                 o_relocations_used,
    output logic [15:0]                o_fingerprint_out
);
    import cfe_pkg::*;

    localparam logic [IW-1:0] MASK = IW'(BUCKET_COUNT - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD1   = 7'b0000100,
        S_RD2   = 7'b0001000,
        S_ALT   = 7'b0010000,
        S_CHK   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    logic [FP_W-1:0] mem [BUCKET_COUNT];
    logic [FP_W-1:0] r_rdata;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_clr, n_clr;
    logic               r_op, n_op, r_pick, n_pick;
    logic [FP_W-1:0]    r_fp, n_fp, r_e1, n_e1, r_hold, n_hold;
    logic [IW-1:0]      r_i1, n_i1, r_i2, n_i2, r_cur, n_cur;
    logic [LIMIT_W-1:0] r_cnt, n_cnt;
    logic               r_res_ok, n_res_ok;
    logic               r_out_valid, n_out_valid, r_out_ok, n_out_ok;
    logic [7:0]         r_out_cnt, n_out_cnt;
    logic [FP_W-1:0]    r_out_fp, n_out_fp;

    logic               we;
    logic [IW-1:0]      waddr, raddr, alt;
    logic [FP_W-1:0]    wdata, hold_hash;

    assign o_clearing         = (r_state == S_CLEAR);
    assign o_valid            = r_out_valid;
    assign o_ok               = r_out_ok;
    assign o_relocations_used = r_out_cnt;
    assign o_fingerprint_out  = r_out_fp;

    // Alternate bucket of the fingerprint in hand
    assign hold_hash = djb2_word(r_hold);
    assign alt       = r_cur ^ (hold_hash[IW-1:0] & MASK);

    // Bucket table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_pick      = r_pick;
        n_fp        = r_fp;
        n_e1        = r_e1;
        n_hold      = r_hold;
        n_i1        = r_i1;
        n_i2        = r_i2;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid && !i_ready;
        n_out_ok    = r_out_ok;
        n_out_cnt   = r_out_cnt;
        n_out_fp    = r_out_fp;
        we          = 1'b0;
        waddr       = r_cur;
        wdata       = r_hold;
        raddr       = r_cur;
        o_pop       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == IW'(BUCKET_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = i_head_i1;
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_head.op;
                    n_pick  = i_head.pick;
                    n_fp    = i_head.fp;
                    n_i1    = i_head_i1;
                    n_i2    = i_head_i2;
                    n_cnt   = '0;
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                raddr   = r_i2;
                n_e1    = r_rdata;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_state = S_DONE;
                if (r_op == OP_LOOKUP) begin
                    n_res_ok = (r_e1 == r_fp) || (r_rdata == r_fp);
                end else if (r_e1 == '0) begin
                    we       = 1'b1;
                    waddr    = r_i1;
                    wdata    = r_fp;
                    n_res_ok = 1'b1;
                end else if (r_rdata == '0) begin
                    we       = 1'b1;
                    waddr    = r_i2;
                    wdata    = r_fp;
                    n_res_ok = 1'b1;
                end else begin
                    // both full: evict the picked entry
                    we      = 1'b1;
                    waddr   = r_pick ? r_i1 : r_i2;
                    wdata   = r_fp;
                    n_cur   = waddr;
                    n_hold  = r_pick ? r_e1 : r_rdata;
                    n_state = S_ALT;
                end
            end
            S_ALT: begin
                raddr   = alt;
                n_cur   = alt;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_rdata == '0) begin
                    we       = 1'b1;
                    n_res_ok = 1'b1;
                    n_state  = S_DONE;
                end else if (r_cnt >= i_limit) begin
                    // limit reached: drop the fingerprint in hand
                    n_res_ok = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    we      = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_hold  = r_rdata;
                    n_state = S_ALT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_cnt   = r_cnt;
                    n_out_fp    = r_fp;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pick    <= n_pick;
        r_fp      <= n_fp;
        r_e1      <= n_e1;
        r_hold    <= n_hold;
        r_i1      <= n_i1;
        r_i2      <= n_i2;
        r_cur     <= n_cur;
        r_cnt     <= n_cnt;
        r_res_ok  <= n_res_ok;
        r_out_ok  <= n_out_ok;
        r_out_cnt <= n_out_cnt;
        r_out_fp  <= n_out_fp;
    end

endmodule

// ===== rtl/cfe_checker.sv =====
// Port-level checker for the cuckoo filter engine, bound to the top level
`include "cuckoo_filter_engine_assert.svh"

module cfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_ok,
    input logic [7:0]  o_relocations_used,
    input logic [15:0] o_fingerprint_out,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_data
);
    import cfe_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               fail_relocated, at_limit, out_stall;
    logic [24:0]        out_beat;

    assign fail_relocated = o_valid && !o_ok && (o_relocations_used != 8'd0);
    assign at_limit       = (o_relocations_used == r_limit);
    assign out_stall      = o_valid && !i_ready;
    assign out_beat       = {o_ok, o_relocations_used, o_fingerprint_out};

    // Shadow copy of the relocation limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // Table sweep after reset blocks requests, and no result beat appears
    `CFE_ASSERT_ALWAYS(a_reset_blocks, !i_rst_n |=> !o_ready && !o_valid, "busy after reset")

    // A failed insert that relocated stopped exactly at the limit
    `CFE_ASSERT(a_fail_at_limit, fail_relocated |-> at_limit, "failed insert not at limit")

    // Relocations never exceed the limit
    `CFE_ASSERT(a_reloc_bound, o_valid |-> o_relocations_used <= r_limit, "relocations above limit")

    // Stalled result beat holds
    `CFE_ASSERT(a_out_hold, out_stall |=> o_valid && $stable(out_beat), "result changed under stall")

endmodule

bind cuckoo_filter_engine cfe_checker u_cfe_checker (.*);
